FILE: src/rsfd_pkg.sv
// Shared constants, types and configuration layout of the serial frame decoder.
// Depends on nothing; every other file of the block imports it.
package rsfd_pkg;

  // Frame and table geometry
  localparam int FRAME_BYTES    = 16;
  localparam int TABLE_CHANNELS = 8;
  localparam int POS_W          = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W          = $clog2(FRAME_BYTES);
  localparam int TBL_W          = (TABLE_CHANNELS > 1) ? $clog2(TABLE_CHANNELS) : 1;

  // Field widths fixed by the interface
  localparam int BYTE_W  = 8;
  localparam int GAP_W   = 16;
  localparam int SLOT_W  = 3;
  localparam int VAL_W   = 12;
  localparam int PULSE_W = 13;
  localparam int CNT_W   = 4;
  localparam int ID_W    = 4;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam logic [ID_W-1:0]    ID_FIELD_MASK = 4'hF;
  localparam logic [PULSE_W-1:0] PULSE_OFFSET  = 13'd988;

  // Register reset values
  localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 4'd8;
  localparam logic [2:0]       RST_ID_SHIFT      = 3'd3;
  localparam logic [3:0]       RST_VALUE_MASK    = 4'h7;
  localparam logic [1:0]       RST_VALUE_SHIFT   = 2'd1;
  localparam logic [GAP_W-1:0] RST_GAP_THRESHOLD = 16'd2500;

  typedef enum logic [CIDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_ID_SHIFT      = 3'd1,
    REG_VALUE_MASK    = 3'd2,
    REG_VALUE_SHIFT   = 3'd3,
    REG_GAP_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic [2:0]       id_shift;
    logic [3:0]       value_mask;
    logic [1:0]       value_shift;
    logic [GAP_W-1:0] gap_threshold_us;
  } cfg_t;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [VAL_W-1:0]  chan_val_t;

  // Downstream status seen by the capture stage
  typedef struct packed {
    logic parse_pending;
    logic emit_busy;
  } hold_t;

endpackage

FILE: src/rsfd_capture.sv
// Byte capture stage: gap test, frame store and write position.
// Depends on rsfd_pkg.
module rsfd_capture (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rsfd_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic [rsfd_pkg::GAP_W-1:0]   in_gap_us,
  input  rsfd_pkg::cfg_t               cfg,
  input  rsfd_pkg::hold_t              hold,
  output rsfd_pkg::byte_t              frame [rsfd_pkg::FRAME_BYTES],
  output logic                         complete
);
  import rsfd_pkg::*;

  byte_t            store_r [FRAME_BYTES];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_eff;
  logic             complete_r, complete_nxt;
  logic             accept;
  logic             gap_hit;

  // Hold only a byte that may complete a frame while the last one is in flight
  assign in_ready = !((pos_r == POS_W'(FRAME_BYTES - 1)) &&
                      (hold.parse_pending || hold.emit_busy || complete_r));
  assign accept   = in_valid && in_ready;
  assign gap_hit  = in_gap_us > cfg.gap_threshold_us;
  assign pos_eff  = gap_hit ? '0 : pos_r;

  // Advance position; drop the byte when the frame is already full
  always_comb begin
    pos_nxt      = pos_r;
    complete_nxt = 1'b0;
    if (accept) begin
      if (pos_eff < POS_W'(FRAME_BYTES)) begin
        pos_nxt      = pos_eff + POS_W'(1);
        complete_nxt = (pos_eff + POS_W'(1)) == POS_W'(FRAME_BYTES);
      end else begin
        pos_nxt = pos_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      complete_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      complete_r <= complete_nxt;
    end
  end

  // Store the byte at the current position
  always_ff @(posedge clk) begin
    if (accept && (pos_eff < POS_W'(FRAME_BYTES))) begin
      store_r[pos_eff[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  assign frame    = store_r;
  assign complete = complete_r;

endmodule

FILE: src/rsfd_parser.sv
// Frame parser: decodes the byte pairs of a full frame into the channel table.
// Depends on rsfd_pkg.
module rsfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               complete,
  input  rsfd_pkg::byte_t    frame [rsfd_pkg::FRAME_BYTES],
  input  rsfd_pkg::cfg_t     cfg,
  output rsfd_pkg::chan_val_t table_out [rsfd_pkg::TABLE_CHANNELS],
  output rsfd_pkg::byte_t    fade_out,
  output logic               start
);
  import rsfd_pkg::*;

  chan_val_t table_r [TABLE_CHANNELS];
  chan_val_t table_nxt [TABLE_CHANNELS];
  byte_t     fade_r;
  logic      start_r;

  // Walk the pairs in frame order; a later pair with the same id wins
  always_comb begin
    byte_t            hi;
    byte_t            lo;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] assembled;
    hi        = '0;
    lo        = '0;
    id        = '0;
    assembled = '0;
    table_nxt = table_r;
    for (int b = 2; b + 1 < FRAME_BYTES; b += 2) begin
      hi        = frame[b];
      lo        = frame[b + 1];
      id        = ID_W'(hi >> cfg.id_shift) & ID_FIELD_MASK;
      assembled = {hi[3:0] & cfg.value_mask, lo};
      if ((id < cfg.channel_count) && (ID_W'(id) < ID_W'(TABLE_CHANNELS))) begin
        table_nxt[id[TBL_W-1:0]] = assembled >> cfg.value_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_CHANNELS; i++) begin
        table_r[i] <= '0;
      end
      fade_r  <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= complete;
      if (complete) begin
        table_r <= table_nxt;
        fade_r  <= frame[0];
      end
    end
  end

  assign table_out = table_r;
  assign fade_out  = fade_r;
  assign start     = start_r;

endmodule

FILE: src/rsfd_emitter.sv
// Result sequencer: walks the configured slots into the output register.
// Depends on rsfd_pkg.
module rsfd_emitter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  rsfd_pkg::chan_val_t           table_in [rsfd_pkg::TABLE_CHANNELS],
  input  rsfd_pkg::byte_t               fade_in,
  input  logic [rsfd_pkg::CNT_W-1:0]    channel_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsfd_pkg::SLOT_W-1:0]   out_channel_slot,
  output logic [rsfd_pkg::VAL_W-1:0]    out_raw_value,
  output logic [rsfd_pkg::PULSE_W-1:0]  out_pulse_width_us,
  output logic [rsfd_pkg::BYTE_W-1:0]   out_fade_count,
  output logic                          out_last_of_frame,
  output logic                          busy
);
  import rsfd_pkg::*;

  logic              active_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  n_lim;
  logic              load;
  logic              is_last;
  logic              out_valid_r;
  logic [SLOT_W-1:0] slot_out_r;
  chan_val_t         raw_r;
  logic [PULSE_W-1:0] pulse_r;
  byte_t             fade_r;
  logic              last_r;

  assign n_lim   = (channel_count > CNT_W'(TABLE_CHANNELS)) ? CNT_W'(TABLE_CHANNELS)
                                                            : channel_count;
  assign load    = active_r && (!out_valid_r || out_ready);
  assign is_last = (CNT_W'(slot_r) + CNT_W'(1)) == n_r;

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      slot_r      <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        active_r <= n_lim != '0;
        slot_r   <= '0;
        n_r      <= n_lim;
      end else if (load) begin
        if (is_last) begin
          active_r <= 1'b0;
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      slot_out_r <= slot_r;
      raw_r      <= table_in[slot_r[TBL_W-1:0]];
      pulse_r    <= PULSE_W'(table_in[slot_r[TBL_W-1:0]]) + PULSE_OFFSET;
      fade_r     <= fade_in;
      last_r     <= is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_slot   = slot_out_r;
  assign out_raw_value      = raw_r;
  assign out_pulse_width_us = pulse_r;
  assign out_fade_count     = fade_r;
  assign out_last_of_frame  = last_r;
  assign busy               = active_r || out_valid_r;

endmodule

FILE: src/rc_serial_frame_decoder_unit.sv
// Top level of the serial frame decoder: configuration registers and stage wiring.
// Depends on rsfd_pkg, rsfd_capture, rsfd_parser and rsfd_emitter.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    rx_byte, gap_us
//   out_     output     out_valid / out_ready  channel_slot, raw_value,
//                                               pulse_width_us, fade_count,
//                                               last_of_frame
//   cfg_     input      cfg_valid / cfg_ready  index, data
//
// One byte is taken per cycle while in_ready is high. The byte that completes a frame
// is parsed in the next cycle, the slot sequencer starts in the cycle after and then
// registers the first result; the rest follow one per cycle while out_ready is high,
// so up to TABLE_CHANNELS results follow in a burst. A byte that could complete the
// next frame waits while the previous frame's results are still being delivered.
// Synchronous reset clears position, table and fade count; config gets reset values.
module rc_serial_frame_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rsfd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic [rsfd_pkg::GAP_W-1:0]    in_gap_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsfd_pkg::SLOT_W-1:0]   out_channel_slot,
  output logic [rsfd_pkg::VAL_W-1:0]    out_raw_value,
  output logic [rsfd_pkg::PULSE_W-1:0]  out_pulse_width_us,
  output logic [rsfd_pkg::BYTE_W-1:0]   out_fade_count,
  output logic                          out_last_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsfd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rsfd_pkg::CDATA_W-1:0]  cfg_data
);
  import rsfd_pkg::*;

  cfg_t      cfg_r;
  hold_t     hold;
  byte_t     frame [FRAME_BYTES];
  chan_val_t table_w [TABLE_CHANNELS];
  byte_t     fade_w;
  logic      complete;
  logic      start;
  logic      emit_busy;

  assign cfg_ready = 1'b1;

  // Write configuration; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count    <= RST_CHANNEL_COUNT;
      cfg_r.id_shift         <= RST_ID_SHIFT;
      cfg_r.value_mask       <= RST_VALUE_MASK;
      cfg_r.value_shift      <= RST_VALUE_SHIFT;
      cfg_r.gap_threshold_us <= RST_GAP_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: cfg_r.channel_count    <= cfg_data[CNT_W-1:0];
        REG_ID_SHIFT:      cfg_r.id_shift         <= cfg_data[2:0];
        REG_VALUE_MASK:    cfg_r.value_mask       <= cfg_data[3:0];
        REG_VALUE_SHIFT:   cfg_r.value_shift      <= cfg_data[1:0];
        REG_GAP_THRESHOLD: cfg_r.gap_threshold_us <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign hold.parse_pending = start;
  assign hold.emit_busy     = emit_busy;

  rsfd_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .in_gap_us  (in_gap_us),
    .cfg        (cfg_r),
    .hold       (hold),
    .frame      (frame),
    .complete   (complete)
  );

  rsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .complete  (complete),
    .frame     (frame),
    .cfg       (cfg_r),
    .table_out (table_w),
    .fade_out  (fade_w),
    .start     (start)
  );

  rsfd_emitter u_emitter (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .table_in           (table_w),
    .fade_in            (fade_w),
    .channel_count      (cfg_r.channel_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_slot   (out_channel_slot),
    .out_raw_value      (out_raw_value),
    .out_pulse_width_us (out_pulse_width_us),
    .out_fade_count     (out_fade_count),
    .out_last_of_frame  (out_last_of_frame),
    .busy               (emit_busy)
  );

endmodule

FILE: src/rsfd_checker.sv
// Port-level checks of the serial frame decoder, bound to its top level.
// Depends on rsfd_pkg and rc_serial_frame_decoder_unit.
module rsfd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rsfd_pkg::SLOT_W-1:0]   out_channel_slot,
  input logic [rsfd_pkg::VAL_W-1:0]    out_raw_value,
  input logic [rsfd_pkg::PULSE_W-1:0]  out_pulse_width_us,
  input logic [rsfd_pkg::BYTE_W-1:0]   out_fade_count,
  input logic                          out_last_of_frame
);
  import rsfd_pkg::*;

  // A stalled result transaction holds its slot, raw value and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_slot) &&
      $stable(out_raw_value) && $stable(out_last_of_frame))
    else $error("result changed while stalled");

  // Pulse width is the raw value plus the fixed offset
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pulse_width_us == (PULSE_W'(out_raw_value) + PULSE_OFFSET))
    else $error("pulse width does not match raw value");

  // Results of one frame come back to back in slot order
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_frame |=>
      out_valid && (out_channel_slot == $past(out_channel_slot) + SLOT_W'(1)))
    else $error("frame results not contiguous");

  // Fade count stays fixed across one frame's results
  a_fade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_frame |=> $stable(out_fade_count))
    else $error("fade count changed within a frame");

endmodule

bind rc_serial_frame_decoder_unit rsfd_checker u_rsfd_checker (.*);
